>>> src/sght_pkg.sv
// Shared types and constants for the sprite grid hit test unit.
// Holds the transaction payload structs, operation and status codes, and the table entry types.
// No dependencies.
package sght_pkg;

  localparam int MAX_SPRITES = 64;
  localparam int ID_W        = $clog2(MAX_SPRITES);
  localparam int CNT_W       = ID_W + 1;
  localparam int COORD_BITS  = 12;
  localparam int BLOCK_SHIFT = 5;
  localparam int BLK_W       = COORD_BITS - BLOCK_SHIFT;
  localparam int EDGE_W      = COORD_BITS + 1;
  localparam int FAR_BLK_W   = EDGE_W - BLOCK_SHIFT;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_MOVE     = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_UNUSED   = 2'd3
  } sght_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NONE    = 2'd2,
    ST_UNKNOWN = 2'd3
  } sght_status_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;
    logic [ID_W-1:0]       target_id;
    logic signed [11:0]    shift_x;
    logic signed [11:0]    shift_y;
    logic [COORD_BITS-1:0] probe_x;
    logic [COORD_BITS-1:0] probe_y;
  } sght_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] result_id;
  } sght_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
  } sght_rect_t;

  typedef struct packed {
    logic [BLK_W-1:0]     bx_left;
    logic [BLK_W-1:0]     by_top;
    logic [FAR_BLK_W-1:0] bx_right;
    logic [FAR_BLK_W-1:0] by_bottom;
  } sght_blk_t;

  typedef struct packed {
    logic            rect_we;
    logic            blk_we;
    logic [ID_W-1:0] wr_addr;
    sght_rect_t      wr_rect;
    sght_blk_t       wr_blk;
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
  } sght_mem_req_t;

endpackage

>>> src/sprite_grid_hit_test_unit.sv
// Sprite grid hit test unit: top level with control sequencer and result register.
// Depends on sght_pkg and sght_store.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | sght_in_t
//   out_    | output    | out_valid/out_stall| sght_out_t
//
// Register, unknown-id and unused-code transactions pass from idle through the execute and
// done states; a move adds a write-back state between execute and done.
// A lookup scans the stored sprites in index order and returns the first match, or none when
// no stored sprite matches. The scan reads one table entry per cycle through the read port.
// Reset clears the sprite count and the control state; table contents stay undefined.
// The input stalls during reset and from acceptance until the result enters the output
// register, and a finished result waits in the result register while a held result is stalled.
module sprite_grid_hit_test_unit import sght_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sght_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output sght_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE_WR,
    S_SCAN,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  sght_in_t      item_r, item_nxt;
  sght_out_t     res_r, res_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [ID_W-1:0] pend_idx_r, pend_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  sght_out_t     out_data_r, out_data_nxt;

  sght_mem_req_t req;
  sght_rect_t    rd_rect;
  sght_blk_t     rd_blk;

  logic [EDGE_W-1:0]    new_right;
  logic [EDGE_W-1:0]    new_bottom;
  logic [BLK_W-1:0]     probe_bx;
  logic [BLK_W-1:0]     probe_by;
  logic                 block_hit;
  logic                 rect_hit;
  logic                 hit;
  sght_rect_t           moved_rect;

  sght_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_rect (rd_rect),
    .rd_blk  (rd_blk)
  );

  function automatic logic [COORD_BITS-1:0] shift_sat(input logic [COORD_BITS-1:0] base,
                                                      input logic signed [11:0] d);
    logic signed [COORD_BITS+1:0] sum;
    sum = $signed({2'b00, base}) + (COORD_BITS+2)'(d);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, {COORD_BITS{1'b1}}})) begin
      return {COORD_BITS{1'b1}};
    end
    return sum[COORD_BITS-1:0];
  endfunction

  always_comb begin
    new_right  = {1'b0, item_r.rect_left} + {1'b0, item_r.rect_width};
    new_bottom = {1'b0, item_r.rect_top} + {1'b0, item_r.rect_height};
    probe_bx   = item_r.probe_x[COORD_BITS-1:BLOCK_SHIFT];
    probe_by   = item_r.probe_y[COORD_BITS-1:BLOCK_SHIFT];
    block_hit  = (rd_blk.bx_left == probe_bx && rd_blk.by_top == probe_by) ||
                 (rd_blk.bx_right == FAR_BLK_W'(probe_bx) && rd_blk.by_top == probe_by) ||
                 (rd_blk.bx_right == FAR_BLK_W'(probe_bx) &&
                  rd_blk.by_bottom == FAR_BLK_W'(probe_by));
    rect_hit   = (item_r.probe_x >= rd_rect.left) &&
                 ({1'b0, item_r.probe_x} < ({1'b0, rd_rect.left} + {1'b0, rd_rect.width})) &&
                 (item_r.probe_y >= rd_rect.top) &&
                 ({1'b0, item_r.probe_y} < ({1'b0, rd_rect.top} + {1'b0, rd_rect.height}));
    hit        = pend_r && block_hit && rect_hit;
    moved_rect        = rd_rect;
    moved_rect.left   = shift_sat(rd_rect.left, item_r.shift_x);
    moved_rect.top    = shift_sat(rd_rect.top, item_r.shift_y);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    req           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt = '{status: ST_OK, result_id: '0};
        state_nxt = S_DONE;
        unique case (item_r.operation)
          OP_REGISTER: begin
            if (count_r == CNT_W'(MAX_SPRITES)) begin
              res_nxt.status = ST_FULL;
            end else begin
              req.rect_we            = 1'b1;
              req.blk_we             = 1'b1;
              req.wr_addr            = count_r[ID_W-1:0];
              req.wr_rect.left       = item_r.rect_left;
              req.wr_rect.top        = item_r.rect_top;
              req.wr_rect.width      = item_r.rect_width;
              req.wr_rect.height     = item_r.rect_height;
              req.wr_blk.bx_left     = item_r.rect_left[COORD_BITS-1:BLOCK_SHIFT];
              req.wr_blk.by_top      = item_r.rect_top[COORD_BITS-1:BLOCK_SHIFT];
              req.wr_blk.bx_right    = new_right[EDGE_W-1:BLOCK_SHIFT];
              req.wr_blk.by_bottom   = new_bottom[EDGE_W-1:BLOCK_SHIFT];
              res_nxt.result_id      = count_r[ID_W-1:0];
              count_nxt              = count_r + 1'b1;
            end
          end
          OP_MOVE: begin
            if ({1'b0, item_r.target_id} >= count_r) begin
              res_nxt.status = ST_UNKNOWN;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = item_r.target_id;
              state_nxt   = S_MOVE_WR;
            end
          end
          OP_LOOKUP: begin
            rd_idx_nxt = '0;
            pend_nxt   = 1'b0;
            state_nxt  = S_SCAN;
          end
          default: begin
            res_nxt.status = ST_OK;
          end
        endcase
      end
      S_MOVE_WR: begin
        req.rect_we = 1'b1;
        req.wr_addr = item_r.target_id;
        req.wr_rect = moved_rect;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        if (hit) begin
          res_nxt   = '{status: ST_OK, result_id: pend_idx_r};
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (rd_idx_r < count_r) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = rd_idx_r[ID_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[ID_W-1:0];
          rd_idx_nxt   = rd_idx_r + 1'b1;
        end else begin
          res_nxt   = '{status: ST_NONE, result_id: '0};
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sprite count never passes the table depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(MAX_SPRITES))
    else $error("sprite count exceeds table depth");

  // A block entry is written only into a free slot at the current count.
  assert property (@(posedge clk) disable iff (!rst_n)
    req.blk_we |-> (count_r < CNT_W'(MAX_SPRITES) && req.wr_addr == count_r[ID_W-1:0]))
    else $error("block entry written outside the free slot");

  // The scan never reads beyond the stored sprites.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && req.rd_en) |-> (rd_idx_r < count_r))
    else $error("scan read beyond stored sprites");

  // A result is loaded only while the output register is free or draining.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && out_data_r == $past(out_data_r)))
    else $error("pending result overwritten");

  // An accepted transaction moves the sequencer out of idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted transaction not executed");

endmodule

>>> src/sght_store.sv
// Sprite table storage: rectangle memory and grid block memory.
// One write port and one registered read port per memory, sharing addresses.
// Depends on sght_pkg.
module sght_store import sght_pkg::*; (
  input  logic          clk,
  input  sght_mem_req_t req,
  output sght_rect_t    rd_rect,
  output sght_blk_t     rd_blk
);

  sght_rect_t rect_mem_r [MAX_SPRITES];
  sght_blk_t  blk_mem_r  [MAX_SPRITES];
  sght_rect_t rd_rect_r;
  sght_blk_t  rd_blk_r;

  always_ff @(posedge clk) begin
    if (req.rect_we) begin
      rect_mem_r[req.wr_addr] <= req.wr_rect;
    end
    if (req.rd_en) begin
      rd_rect_r <= rect_mem_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.blk_we) begin
      blk_mem_r[req.wr_addr] <= req.wr_blk;
    end
    if (req.rd_en) begin
      rd_blk_r <= blk_mem_r[req.rd_addr];
    end
  end

  assign rd_rect = rd_rect_r;
  assign rd_blk  = rd_blk_r;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for sprite_grid_hit_test_unit: directed and random register, move
// and lookup transactions, with an in-house predictor and an in-order result scoreboard.
// Depends on sght_pkg and the sprite_grid_hit_test_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import sght_pkg::*;

  localparam int RANDOM_ITEMS  = 600;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 100;
  localparam int COORD_TOP     = (1 << COORD_BITS) - 1;

  class hit_test_scoreboard;
    sght_rect_t  rects [MAX_SPRITES];
    sght_blk_t   blocks [MAX_SPRITES];
    int unsigned sprite_count;
    sght_out_t   expected_q [$];
    int          errors;

    function int shifted_edge(logic [COORD_BITS-1:0] base, logic signed [11:0] delta);
      int sum;
      sum = int'(base) + int'(delta);
      if (sum < 0) return 0;
      if (sum > COORD_TOP) return COORD_TOP;
      return sum;
    endfunction

    function sght_out_t predict_hit(sght_in_t item);
      sght_out_t  res;
      sght_rect_t r;
      sght_blk_t  b;
      int         right, bottom, px, py, pbx, pby;
      bit         held, covers;
      res.status    = ST_OK;
      res.result_id = '0;
      case (item.operation)
        OP_REGISTER: begin
          if (sprite_count >= MAX_SPRITES) begin
            res.status = ST_FULL;
          end else begin
            right  = int'(item.rect_left) + int'(item.rect_width);
            bottom = int'(item.rect_top) + int'(item.rect_height);
            r.left   = item.rect_left;
            r.top    = item.rect_top;
            r.width  = item.rect_width;
            r.height = item.rect_height;
            b.bx_left   = BLK_W'(int'(item.rect_left) >> BLOCK_SHIFT);
            b.by_top    = BLK_W'(int'(item.rect_top) >> BLOCK_SHIFT);
            b.bx_right  = FAR_BLK_W'(right >> BLOCK_SHIFT);
            b.by_bottom = FAR_BLK_W'(bottom >> BLOCK_SHIFT);
            rects[sprite_count]  = r;
            blocks[sprite_count] = b;
            res.result_id = ID_W'(sprite_count);
            sprite_count++;
          end
        end
        OP_MOVE: begin
          if (item.target_id >= sprite_count) begin
            res.status = ST_UNKNOWN;
          end else begin
            r = rects[item.target_id];
            r.left = COORD_BITS'(shifted_edge(r.left, item.shift_x));
            r.top  = COORD_BITS'(shifted_edge(r.top, item.shift_y));
            rects[item.target_id] = r;
          end
        end
        OP_LOOKUP: begin
          px  = int'(item.probe_x);
          py  = int'(item.probe_y);
          pbx = px >> BLOCK_SHIFT;
          pby = py >> BLOCK_SHIFT;
          res.status = ST_NONE;
          for (int i = 0; i < sprite_count; i++) begin
            r = rects[i];
            b = blocks[i];
            held = (int'(b.bx_left) == pbx && int'(b.by_top) == pby) ||
                   (int'(b.bx_right) == pbx && int'(b.by_top) == pby) ||
                   (int'(b.bx_right) == pbx && int'(b.by_bottom) == pby);
            covers = px >= int'(r.left) && px < int'(r.left) + int'(r.width) &&
                     py >= int'(r.top) && py < int'(r.top) + int'(r.height);
            if (held && covers) begin
              res.status    = ST_OK;
              res.result_id = ID_W'(i);
              break;
            end
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(sght_in_t item);
      expected_q = {expected_q, predict_hit(item)};
    endfunction

    function void check_result(sght_out_t got);
      sght_out_t want;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: status %0d result_id %0d",
               got.status, got.result_id);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.result_id !== want.result_id) begin
        $error("result_id: expected %0d, actual %0d", want.result_id, got.result_id);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  sght_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sght_out_t out_data;

  hit_test_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_go       = 1'b0;
  logic        hold_active   = 1'b0;

  sprite_grid_hit_test_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAIL sprite_grid_hit_test_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_active) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  function automatic sght_in_t noise_item(sght_op_t op);
    logic [127:0] bits;
    sght_in_t     it;
    bits = {$urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(sght_in_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  function automatic sght_in_t reg_item(int l, int t, int w, int h);
    sght_in_t it;
    it = noise_item(OP_REGISTER);
    it.rect_left   = COORD_BITS'(l);
    it.rect_top    = COORD_BITS'(t);
    it.rect_width  = COORD_BITS'(w);
    it.rect_height = COORD_BITS'(h);
    return it;
  endfunction

  function automatic sght_in_t move_item(int id, int dx, int dy);
    sght_in_t it;
    it = noise_item(OP_MOVE);
    it.target_id = ID_W'(id);
    it.shift_x   = 12'(dx);
    it.shift_y   = 12'(dy);
    return it;
  endfunction

  function automatic sght_in_t probe_item(int x, int y);
    sght_in_t it;
    it = noise_item(OP_LOOKUP);
    it.probe_x = COORD_BITS'(x);
    it.probe_y = COORD_BITS'(y);
    return it;
  endfunction

  function automatic sght_in_t random_item();
    sght_in_t   it;
    sght_rect_t r;
    int         pick, id, w, h, px, py;
    bit         full;
    full = sb.sprite_count >= MAX_SPRITES;
    pick = $urandom_range(99);
    if (pick < (full ? 4 : 30)) begin
      w = ($urandom_range(9) < 8) ? $urandom_range(96) : $urandom_range(COORD_TOP);
      h = ($urandom_range(9) < 8) ? $urandom_range(96) : $urandom_range(COORD_TOP);
      it = reg_item($urandom_range(COORD_TOP), $urandom_range(COORD_TOP), w, h);
    end else if (pick < 55) begin
      if (sb.sprite_count > 0 && $urandom_range(9) < 8) begin
        id = $urandom_range(sb.sprite_count - 1);
      end else begin
        id = $urandom_range(63);
      end
      if ($urandom_range(3) != 0) begin
        it = move_item(id, int'($urandom_range(96)) - 48, int'($urandom_range(96)) - 48);
      end else begin
        it = move_item(id, int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048);
      end
    end else if (pick < 95) begin
      if (sb.sprite_count == 0 || $urandom_range(99) < 15) begin
        it = probe_item($urandom_range(COORD_TOP), $urandom_range(COORD_TOP));
      end else begin
        r  = sb.rects[$urandom_range(sb.sprite_count - 1)];
        px = int'(r.left) + ((r.width != 0) ? int'($urandom_range(r.width - 1)) : 0);
        py = int'(r.top) + ((r.height != 0) ? int'($urandom_range(r.height - 1)) : 0);
        if ($urandom_range(4) == 0) begin
          if ($urandom_range(1) == 0) px = int'(r.left) + int'(r.width);
          else py = int'(r.top) + int'(r.height);
        end
        it = probe_item(px, py);
      end
    end else begin
      it = noise_item(OP_UNUSED);
    end
    return it;
  endfunction

  task automatic send_item(sght_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
  endtask

  initial begin
    int unsigned phase;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, then corner cases of rectangles, blocks and moves.
    send_item(probe_item(0, 0));
    send_item(move_item(0, 5, 5));
    send_item(noise_item(OP_UNUSED));
    send_item(reg_item(0, 0, 40, 40));
    send_item(reg_item(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP));
    send_item(reg_item(100, 100, 0, 50));
    send_item(reg_item(64, 64, 64, 64));
    send_item(probe_item(0, 0));
    send_item(probe_item(39, 39));
    send_item(probe_item(40, 10));
    send_item(probe_item(COORD_TOP, COORD_TOP));
    send_item(probe_item(100, 120));
    send_item(probe_item(127, 127));
    send_item(probe_item(64, 64));
    send_item(move_item(3, -2048, -2048));
    send_item(probe_item(64, 64));
    send_item(probe_item(5, 5));
    send_item(move_item(0, 2047, 2047));
    send_item(move_item(1, 2047, 2047));
    send_item(move_item(63, -1, -1));
    send_item(move_item(4, 0, 0));
    send_item(probe_item(COORD_TOP, COORD_TOP));
    send_item(reg_item(0, COORD_TOP, COORD_TOP, 0));
    send_item(noise_item(OP_UNUSED));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n * 5 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 73;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 73;
        end
        3: begin
          send_idle_pct = 14;
          stall_pct <= 14;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct <= 0;
          hold_go   <= 1'b1;
        end
      endcase
      send_item(random_item());
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS sprite_grid_hit_test_unit");
    end else begin
      $display("FAIL sprite_grid_hit_test_unit");
    end
    $finish;
  end

endmodule
